/* sv/nsf_pkg.sv */
package nsf_pkg;

  // Sentence length limit: the buffer size less a safety margin.
  localparam int BUFFER_BYTES = 128;
  localparam int LIMIT_MARGIN = 5;
  localparam logic [7:0] SENTENCE_LIMIT = 8'(BUFFER_BYTES - LIMIT_MARGIN);

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] CHAR_STAR   = 8'h2A;  // '*'
  localparam logic [7:0] CHAR_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CHAR_HEX_A  = 8'h37;  // 'A' - 0xA

  typedef struct packed {
    logic [7:0] echo_byte;
    logic       stored;
    logic [6:0] position;
    logic       sentence_start;
    logic       overflow_abort;
    logic       sentence_done;
    logic       checksum_good;
    logic [7:0] sentence_length;
  } result_t;

  // Uppercase ASCII hex digit of one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    return (nib < 4'hA) ? (wide + CHAR_ZERO) : (wide + CHAR_HEX_A);
  endfunction

endpackage

/* sv/nmea_sentence_framer.sv */
// Channel  | dir | tdata (low bit up)                          | tuser / tlast
// ---------+-----+---------------------------------------------+----------------------------
// s_axis   | in  | rx_byte[7:0]                                | -
// m_axis   | out | echo_byte[7:0] position[14:8] length[22:15] | tuser: stored, start,
//          |     |                                             | overflow, good; tlast: done
//
// Throughput is one item per cycle unless m_axis stalls. A byte goes through
// the input and result registers, with the core step (mode, count and running
// XOR update) combinational between them. Reset is synchronous and active high;
// it clears both valid flags and the framer state. A stall on m_axis holds the
// result register, then the input register, then drops s_axis_tready.
module nmea_sentence_framer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // echo_byte[7:0], position[14:8],
                                      // sentence_length[22:15], zero[23]
  output logic [3:0]  m_axis_tuser,   // stored[0], sentence_start[1],
                                      // overflow_abort[2], checksum_good[3]
  output logic        m_axis_tlast    // sentence_done
);

  logic             held_valid;
  logic [7:0]       held_byte;
  logic             out_free;
  logic             step;
  nsf_pkg::result_t core_res;
  nsf_pkg::result_t out_res;

  // An item moves into the core only when the result register has room.
  assign step = held_valid && out_free;

  nsf_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .take       (step),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  nsf_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (held_byte),
    .res     (core_res)
  );

  nsf_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .res_in    (core_res),
    .free      (out_free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .res_out   (out_res)
  );

  assign m_axis_tdata = {1'b0, out_res.sentence_length, out_res.position, out_res.echo_byte};
  assign m_axis_tuser = {out_res.checksum_good, out_res.overflow_abort,
                         out_res.sentence_start, out_res.stored};
  assign m_axis_tlast = out_res.sentence_done;

endmodule

/* sv/nsf_in_reg.sv */
module nsf_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       take,       // core consumes the held byte this cycle
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic fire;

  assign in_ready = !held_valid || take;
  assign fire     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (fire) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      held_byte <= in_byte;
    end
  end

endmodule

/* sv/nsf_core.sv */
module nsf_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,     // one byte processed this cycle
  input  logic [7:0]       rx_byte,
  output nsf_pkg::result_t res
);

  localparam logic [1:0] MODE_HUNT    = 2'd0;
  localparam logic [1:0] MODE_COLLECT = 2'd1;
  localparam logic [1:0] MODE_STAR    = 2'd2;
  localparam logic [1:0] MODE_CS1     = 2'd3;

  logic [1:0] hunt_mode, hunt_mode_next;
  logic [7:0] byte_count, byte_count_next;
  logic [7:0] running_xor, running_xor_next;
  logic [7:0] first_check_char, first_check_char_next;
  logic [7:0] count_inc;

  assign count_inc = byte_count + 8'd1;

  always_comb begin
    hunt_mode_next        = hunt_mode;
    byte_count_next       = byte_count;
    running_xor_next      = running_xor;
    first_check_char_next = first_check_char;

    res                 = '0;
    res.echo_byte       = rx_byte;

    unique case (hunt_mode)
      MODE_HUNT: begin
        if (rx_byte == nsf_pkg::CHAR_DOLLAR) begin
          hunt_mode_next     = MODE_COLLECT;
          byte_count_next    = 8'd1;
          running_xor_next   = '0;
          res.stored         = 1'b1;
          res.sentence_start = 1'b1;
        end
      end
      MODE_COLLECT: begin
        if (rx_byte == nsf_pkg::CHAR_DOLLAR) begin
          byte_count_next    = 8'd1;
          running_xor_next   = '0;
          res.stored         = 1'b1;
          res.sentence_start = 1'b1;
        end else if (byte_count >= nsf_pkg::SENTENCE_LIMIT) begin
          hunt_mode_next     = MODE_HUNT;
          byte_count_next    = '0;
          running_xor_next   = '0;
          res.overflow_abort = 1'b1;
        end else begin
          if (rx_byte == nsf_pkg::CHAR_STAR) begin
            hunt_mode_next = MODE_STAR;
          end else begin
            running_xor_next = running_xor ^ rx_byte;
          end
          res.stored      = 1'b1;
          res.position    = byte_count[6:0];
          byte_count_next = count_inc;
        end
      end
      MODE_STAR: begin
        first_check_char_next = rx_byte;
        hunt_mode_next        = MODE_CS1;
        res.stored            = 1'b1;
        res.position          = byte_count[6:0];
        byte_count_next       = count_inc;
      end
      MODE_CS1: begin
        res.stored          = 1'b1;
        res.position        = byte_count[6:0];
        res.sentence_length = count_inc;
        res.sentence_done   = 1'b1;
        res.checksum_good   =
          (nsf_pkg::hex_char(running_xor[7:4]) == first_check_char) &&
          (nsf_pkg::hex_char(running_xor[3:0]) == rx_byte);
        hunt_mode_next   = MODE_HUNT;
        byte_count_next  = '0;
        running_xor_next = '0;
      end
      default: begin
        hunt_mode_next = MODE_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hunt_mode        <= MODE_HUNT;
      byte_count       <= '0;
      running_xor      <= '0;
      first_check_char <= '0;
    end else if (step) begin
      hunt_mode        <= hunt_mode_next;
      byte_count       <= byte_count_next;
      running_xor      <= running_xor_next;
      first_check_char <= first_check_char_next;
    end
  end

`ifndef SYNTHESIS
  // A finished sentence always sends the framer back to hunting.
  a_done_to_hunt: assert property (@(posedge clk) disable iff (rst)
    (step && res.sentence_done) |=> (hunt_mode == MODE_HUNT))
    else $error("sentence_done did not return to hunt");

  // A start always marks a stored byte at position zero.
  a_start_pos: assert property (@(posedge clk) disable iff (rst)
    (step && res.sentence_start) |-> (res.stored && res.position == 7'd0))
    else $error("sentence_start with bad position");

  // Dropped bytes are never stored.
  a_ovf_not_stored: assert property (@(posedge clk) disable iff (rst)
    (step && res.overflow_abort) |-> !res.stored)
    else $error("overflow byte was stored");

  // Checksum compare only happens one byte after the '*' state.
  a_done_after_star: assert property (@(posedge clk) disable iff (rst)
    (step && res.sentence_done) |-> (hunt_mode == MODE_CS1))
    else $error("sentence_done outside checksum state");
`endif

endmodule

/* sv/nsf_out_reg.sv */
module nsf_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  nsf_pkg::result_t res_in,
  output logic             free,     // register can take a result this cycle
  output logic             out_valid,
  input  logic             out_ready,
  output nsf_pkg::result_t res_out
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

/* sim/nmea_sentence_framer_tb.sv */
`timescale 1ns / 100ps

// Byte-stream check of the NMEA sentence framer: a short table of directed
// bytes, a run of long sentences at the length limit, then random sentences
// with line noise. Items are checked against typed rows or a local model.
module nmea_sentence_framer_tb;

  // Framing states of the local model.
  typedef enum logic [1:0] {
    HUNTING,
    COLLECTING,
    STAR_SEEN,
    FIRST_DIGIT_SEEN
  } frame_mode_t;

  // How a generated sentence ends.
  typedef enum int {
    TAIL_GOOD,     // '*' and the correct uppercase digits
    TAIL_CORRUPT,  // '*' and digits that may be wrong
    TAIL_LOWER,    // '*' and the correct digits in lowercase
    TAIL_CUT       // no checksum at all
  } tail_kind_t;

  // One directed row: the byte to send and, where typed is set, the result
  // item typed in by hand. Other rows use the local model.
  typedef struct packed {
    logic             typed;
    logic [7:0]       rx;
    nsf_pkg::result_t want;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 25;
  localparam int TOTAL_ITEMS   = 550;
  localparam int STALL_PCT     = 37;
  localparam int REPORT_LIMIT  = 10;

  // Result columns: echo, stored, position, {start, overflow, done, good}, length
  localparam directed_row_t [0:DIRECTED_ROWS-1] DIRECTED = {
    // bytes while hunting are ignored
    {1'b1, 8'h00, 8'h00, 1'b0, 7'd0, 4'b0000, 8'd0},
    {1'b1, 8'hFF, 8'hFF, 1'b0, 7'd0, 4'b0000, 8'd0},
    {1'b1, nsf_pkg::CHAR_STAR, nsf_pkg::CHAR_STAR, 1'b0, 7'd0, 4'b0000, 8'd0},
    // sentence start, body extremes, restart on a second '$'
    {1'b1, nsf_pkg::CHAR_DOLLAR, nsf_pkg::CHAR_DOLLAR, 1'b1, 7'd0, 4'b1000, 8'd0},
    {1'b0, 8'h41, 28'd0},
    {1'b0, 8'h00, 28'd0},
    {1'b0, 8'hFF, 28'd0},
    {1'b1, nsf_pkg::CHAR_DOLLAR, nsf_pkg::CHAR_DOLLAR, 1'b1, 7'd0, 4'b1000, 8'd0},
    // "$A*41": good checksum, length 5
    {1'b0, 8'h41, 28'd0},
    {1'b0, nsf_pkg::CHAR_STAR, 28'd0},
    {1'b0, 8'h34, 28'd0},
    {1'b1, 8'h31, 8'h31, 1'b1, 7'd4, 4'b0011, 8'd5},
    // "$J*4a": lowercase digit never matches
    {1'b0, nsf_pkg::CHAR_DOLLAR, 28'd0},
    {1'b0, 8'h4A, 28'd0},
    {1'b0, nsf_pkg::CHAR_STAR, 28'd0},
    {1'b0, 8'h34, 28'd0},
    {1'b1, 8'h61, 8'h61, 1'b1, 7'd4, 4'b0010, 8'd5},
    // "$*$$": '$' taken as checksum chars, no restart
    {1'b0, nsf_pkg::CHAR_DOLLAR, 28'd0},
    {1'b0, nsf_pkg::CHAR_STAR, 28'd0},
    {1'b1, nsf_pkg::CHAR_DOLLAR, nsf_pkg::CHAR_DOLLAR, 1'b1, 7'd2, 4'b0000, 8'd0},
    {1'b1, nsf_pkg::CHAR_DOLLAR, nsf_pkg::CHAR_DOLLAR, 1'b1, 7'd3, 4'b0010, 8'd4},
    // "$*00": empty body, XOR of nothing is zero
    {1'b0, nsf_pkg::CHAR_DOLLAR, 28'd0},
    {1'b0, nsf_pkg::CHAR_STAR, 28'd0},
    {1'b0, 8'h30, 28'd0},
    {1'b1, 8'h30, 8'h30, 1'b1, 7'd3, 4'b0011, 8'd4}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Local model state.
  frame_mode_t frame_mode  = HUNTING;
  logic [7:0]  frame_count = 8'd0;
  logic [7:0]  frame_xor   = 8'd0;
  logic [7:0]  first_digit = 8'd0;

  nsf_pkg::result_t results_due[$];
  int      stall_pct = STALL_PCT;
  int      mismatches = 0;
  int      bytes_sent = 0;

  nmea_sentence_framer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("** nmea_sentence_framer: FAILED **");
    $finish;
  end

  function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
    return (nib > 4'd9) ? 8'h41 + (nib - 4'd10) : 8'h30 + nib;
  endfunction

  // Advance the local framer by one byte and return its result item.
  function automatic nsf_pkg::result_t frame_byte(input logic [7:0] b);
    nsf_pkg::result_t r;
    r = '0;
    r.echo_byte = b;
    case (frame_mode)
      HUNTING: begin
        if (b == nsf_pkg::CHAR_DOLLAR) begin
          frame_mode  = COLLECTING;
          frame_count = 8'd1;
          frame_xor   = 8'd0;
          r.stored = 1'b1;
          r.sentence_start = 1'b1;
        end
      end
      COLLECTING: begin
        if (b == nsf_pkg::CHAR_DOLLAR) begin
          // restart wins over the length limit
          frame_count = 8'd1;
          frame_xor   = 8'd0;
          r.stored = 1'b1;
          r.sentence_start = 1'b1;
        end else if (frame_count >= nsf_pkg::SENTENCE_LIMIT) begin
          frame_mode  = HUNTING;
          frame_count = 8'd0;
          frame_xor   = 8'd0;
          r.overflow_abort = 1'b1;
        end else begin
          if (b == nsf_pkg::CHAR_STAR) frame_mode = STAR_SEEN;
          else frame_xor = frame_xor ^ b;
          r.stored = 1'b1;
          r.position = frame_count[6:0];
          frame_count = frame_count + 8'd1;
        end
      end
      STAR_SEEN: begin
        first_digit = b;
        frame_mode  = FIRST_DIGIT_SEEN;
        r.stored = 1'b1;
        r.position = frame_count[6:0];
        frame_count = frame_count + 8'd1;
      end
      default: begin
        r.stored = 1'b1;
        r.position = frame_count[6:0];
        r.sentence_done = 1'b1;
        r.sentence_length = frame_count + 8'd1;
        r.checksum_good = (ascii_hex(frame_xor[7:4]) == first_digit) &&
                          (ascii_hex(frame_xor[3:0]) == b);
        frame_mode  = HUNTING;
        frame_count = 8'd0;
        frame_xor   = 8'd0;
      end
    endcase
    return r;
  endfunction

  // Offer one byte with random idle cycles ahead of it, wait for the
  // handshake, then queue its expected result item.
  task automatic push_byte(input logic [7:0] b, input logic typed,
                           input nsf_pkg::result_t want);
    nsf_pkg::result_t predicted;
    while ($urandom_range(99) < stall_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predicted = frame_byte(b);
    results_due.push_back(typed ? want : predicted);
    bytes_sent++;
  endtask

  // Body byte: printable text most of the time, any byte now and then
  // (which may land on '$' or '*').
  function automatic logic [7:0] body_byte(input int wild_pct);
    logic [7:0] b;
    if ($urandom_range(99) < wild_pct) return 8'($urandom_range(255));
    do b = 8'($urandom_range(8'h20, 8'h7E));
    while (b == nsf_pkg::CHAR_DOLLAR || b == nsf_pkg::CHAR_STAR);
    return b;
  endfunction

  task automatic send_sentence(input int body_len, input tail_kind_t tail, input int wild_pct);
    logic [7:0] sum;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] b;
    sum = 8'd0;
    push_byte(nsf_pkg::CHAR_DOLLAR, 1'b0, '0);
    for (int i = 0; i < body_len; i++) begin
      b = body_byte(wild_pct);
      sum ^= b;
      push_byte(b, 1'b0, '0);
    end
    if (tail == TAIL_CUT) return;
    hi = ascii_hex(sum[7:4]);
    lo = ascii_hex(sum[3:0]);
    case (tail)
      TAIL_CORRUPT: begin
        if ($urandom_range(1)) hi = 8'($urandom_range(255));
        else lo = ascii_hex(4'($urandom_range(15)));
      end
      TAIL_LOWER: begin
        // letters move to lowercase, decimal digits stay as they are
        if (hi > 8'h39) hi = hi + 8'h20;
        if (lo > 8'h39) lo = lo + 8'h20;
      end
      default: ;
    endcase
    push_byte(nsf_pkg::CHAR_STAR, 1'b0, '0);
    push_byte(hi, 1'b0, '0);
    push_byte(lo, 1'b0, '0);
  endtask

  // Receiver side: random back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Result check against the oldest expected item.
  always @(posedge clk) begin
    nsf_pkg::result_t got;
    nsf_pkg::result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.echo_byte       = m_axis_tdata[7:0];
      got.position        = m_axis_tdata[14:8];
      got.sentence_length = m_axis_tdata[22:15];
      got.stored          = m_axis_tuser[0];
      got.sentence_start  = m_axis_tuser[1];
      got.overflow_abort  = m_axis_tuser[2];
      got.checksum_good   = m_axis_tuser[3];
      got.sentence_done   = m_axis_tlast;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result item with none expected: tdata=%h tuser=%b tlast=%b",
                   $realtime, m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end else begin
        want = results_due.pop_front();
        if (got !== want || m_axis_tdata[23] !== 1'b0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: mismatch on byte %h (pad bit %b)",
                     $realtime, want.echo_byte, m_axis_tdata[23]);
            $display("  expected echo=%h st=%b pos=%0d start=%b ovf=%b done=%b good=%b len=%0d",
                     want.echo_byte, want.stored, want.position, want.sentence_start,
                     want.overflow_abort, want.sentence_done, want.checksum_good,
                     want.sentence_length);
            $display("  actual   echo=%h st=%b pos=%0d start=%b ovf=%b done=%b good=%b len=%0d",
                     got.echo_byte, got.stored, got.position, got.sentence_start,
                     got.overflow_abort, got.sentence_done, got.checksum_good,
                     got.sentence_length);
          end
        end
      end
    end
  end

  initial begin
    int         pick;
    int         body_len;
    tail_kind_t tail;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    for (int i = 0; i < DIRECTED_ROWS; i++)
      push_byte(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].want);

    // Let everything drain before the long sentences.
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);

    // Length limit, run with no idling on either side: the longest sentence
    // that fits (position 124, length 125), '*' arriving at the limit, and
    // '$' arriving at the limit (restart, not overflow).
    stall_pct = 0;
    send_sentence(int'(nsf_pkg::SENTENCE_LIMIT) - 2, TAIL_GOOD, 0);
    send_sentence(int'(nsf_pkg::SENTENCE_LIMIT) - 1, TAIL_GOOD, 0);
    send_sentence(int'(nsf_pkg::SENTENCE_LIMIT) - 1, TAIL_CUT, 0);
    send_sentence(3, TAIL_GOOD, 0);
    stall_pct = STALL_PCT;

    // Random sentences with line noise between them, up to the item budget.
    while (bytes_sent < TOTAL_ITEMS) begin
      repeat ($urandom_range(3)) push_byte(8'($urandom_range(255)), 1'b0, '0);
      body_len = ($urandom_range(99) < 90) ? $urandom_range(15) : $urandom_range(16, 100);
      pick = $urandom_range(99);
      if (pick < 60) tail = TAIL_GOOD;
      else if (pick < 75) tail = TAIL_CORRUPT;
      else if (pick < 85) tail = TAIL_LOWER;
      else tail = TAIL_CUT;
      send_sentence(body_len, tail, 4);
    end

    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("** nmea_sentence_framer: PASSED **");
    end else begin
      $display("** nmea_sentence_framer: FAILED **");
    end
    $finish;
  end

endmodule
